[rtl/core/spq_pkg.sv]
// ---------------------------------------------------------------------------
// spq_pkg: shared types for the stable priority queue
// Result status codes and the control bundle sent to every queue cell.
// ---------------------------------------------------------------------------
package spq_pkg;

  // Result status of one item
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,  // item done
    ST_EMPTY = 2'd1,  // remove found no entry
    ST_FULL  = 2'd2   // insert dropped, queue full
  } status_e;

  // Per-cycle command broadcast along the cell row
  typedef struct packed {
    logic ins;  // insert the new entry in sorted position
    logic rem;  // pop the head, everything shifts toward slot 0
  } cell_ctrl_t;

endpackage

[rtl/core/stable_priority_queue.sv]
// ---------------------------------------------------------------------------
// stable_priority_queue: sorted ready queue of process identifiers
// Row of shifting cells kept in priority order, head in cell 0. Inserts go
// behind all entries of equal or higher priority; removes pop the head.
// ---------------------------------------------------------------------------
// Channel | Handshake               | Payload
// --------+-------------------------+------------------------------------------
// request | req_valid_i/req_ready_o | mode_i, new_pid_i, new_priority_i
// result  | res_valid_o/res_ready_i | out_valid_o, out_pid_o, out_priority_o,
//         |                         | status_o, occupancy_out_o
//
// One item per cycle while results are taken: every cell compares its priority
// with the new one in parallel and shifts one step, so the queue updates at
// the accepting edge. The result register is loaded at that edge as well.
// A stalled result holds the request side off only while it is not taken.
// Reset empties the queue (count to zero); cell contents need no clearing.
// ---------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  logic       mode_i,
  input  logic [7:0] new_pid_i,
  input  logic [7:0] new_priority_i,
  // result channel
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_pid_o,
  output logic [7:0] out_priority_o,
  output logic [1:0] status_o,
  output logic [4:0] occupancy_out_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                     accept;
  logic                     full, empty;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [PRIORITY_BITS-1:0] prio_in;
  logic [7:0]               head_prio8;
  logic [4:0]               occ5;
  spq_pkg::cell_ctrl_t      ctrl;

  logic [QUEUE_DEPTH-1:0]   occ;
  logic [QUEUE_DEPTH-1:0]   keep;
  logic [7:0]               cell_pid  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];

  logic                     res_valid_q;
  logic                     out_valid_q, out_valid_d;
  logic [7:0]               out_pid_q, out_pid_d;
  logic [7:0]               out_prio_q, out_prio_d;
  spq_pkg::status_e         status_q, status_d;
  logic [4:0]               occ_q;

  // width adaption of priority and occupancy fields
  if (PRIORITY_BITS > 8) begin : g_prio_wide
    assign prio_in    = {{(PRIORITY_BITS-8){1'b0}}, new_priority_i};
    assign head_prio8 = cell_prio[0][7:0];
  end else if (PRIORITY_BITS == 8) begin : g_prio_eq
    assign prio_in    = new_priority_i;
    assign head_prio8 = cell_prio[0];
  end else begin : g_prio_narrow
    assign prio_in    = new_priority_i[PRIORITY_BITS-1:0];
    assign head_prio8 = {{(8-PRIORITY_BITS){1'b0}}, cell_prio[0]};
  end

  if (CNT_W > 5) begin : g_cnt_wide
    assign occ5 = count_d[4:0];
  end else if (CNT_W == 5) begin : g_cnt_eq
    assign occ5 = count_d;
  end else begin : g_cnt_narrow
    assign occ5 = {{(5-CNT_W){1'b0}}, count_d};
  end

  // handshake and command decode
  assign req_ready_o = !res_valid_q || res_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  assign full        = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty       = (count_q == '0);
  assign ctrl.ins    = accept && !mode_i && !full;
  assign ctrl.rem    = accept && mode_i && !empty;

  // entry count
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     lkeep;
    logic [7:0]               lpid, rpid;
    logic [PRIORITY_BITS-1:0] lprio, rprio;

    assign occ[i] = (count_q > CNT_W'(i));

    if (i == 0) begin : g_first
      assign lkeep = 1'b1;
      assign lpid  = '0;
      assign lprio = '0;
    end else begin : g_mid
      assign lkeep = keep[i-1];
      assign lpid  = cell_pid[i-1];
      assign lprio = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH-1) begin : g_last
      assign rpid  = '0;
      assign rprio = '0;
    end else begin : g_inner
      assign rpid  = cell_pid[i+1];
      assign rprio = cell_prio[i+1];
    end

    spq_cell #(
      .PRIO_W(PRIORITY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .new_pid_i   (new_pid_i),
      .new_prio_i  (prio_in),
      .left_keep_i (lkeep),
      .left_pid_i  (lpid),
      .left_prio_i (lprio),
      .right_pid_i (rpid),
      .right_prio_i(rprio),
      .keep_o      (keep[i]),
      .pid_o       (cell_pid[i]),
      .prio_o      (cell_prio[i])
    );
  end

  // result fields
  always_comb begin
    out_valid_d = 1'b0;
    out_pid_d   = '0;
    out_prio_d  = '0;
    status_d    = spq_pkg::ST_OK;
    if (mode_i) begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        out_valid_d = 1'b1;
        out_pid_d   = cell_pid[0];
        out_prio_d  = head_prio8;
      end
    end else if (full) begin
      status_d = spq_pkg::ST_FULL;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_valid_q <= out_valid_d;
      out_pid_q   <= out_pid_d;
      out_prio_q  <= out_prio_d;
      status_q    <= status_d;
      occ_q       <= occ5;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign out_valid_o     = out_valid_q;
  assign out_pid_o       = out_pid_q;
  assign out_priority_o  = out_prio_q;
  assign status_o        = status_q;
  assign occupancy_out_o = occ_q;

endmodule

[rtl/core/spq_cell.sv]
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one identifier and priority. On insert it keeps its entry, takes the
// new entry, or takes its left neighbor's entry; on remove it takes the right
// neighbor's entry.
// ---------------------------------------------------------------------------
module spq_cell #(
  parameter int PRIO_W = 8
) (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,        // slot holds a live entry
  input  logic [7:0]          new_pid_i,
  input  logic [PRIO_W-1:0]   new_prio_i,
  input  logic                left_keep_i,  // left neighbor keeps its entry
  input  logic [7:0]          left_pid_i,
  input  logic [PRIO_W-1:0]   left_prio_i,
  input  logic [7:0]          right_pid_i,
  input  logic [PRIO_W-1:0]   right_prio_i,
  output logic                keep_o,
  output logic [7:0]          pid_o,
  output logic [PRIO_W-1:0]   prio_o
);

  logic [7:0]        pid_q, pid_d;
  logic [PRIO_W-1:0] prio_q, prio_d;

  // entry stays ahead of the new one when equal or higher priority
  assign keep_o = occ_i && (prio_q >= new_prio_i);

  // next slot contents
  always_comb begin
    pid_d  = pid_q;
    prio_d = prio_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          pid_d  = new_pid_i;
          prio_d = new_prio_i;
        end else begin
          pid_d  = left_pid_i;
          prio_d = left_prio_i;
        end
      end
    end else if (ctrl_i.rem) begin
      pid_d  = right_pid_i;
      prio_d = right_prio_i;
    end
  end

  // slot storage, contents are don't-care until written
  always_ff @(posedge clk_i) begin
    pid_q  <= pid_d;
    prio_q <= prio_d;
  end

  assign pid_o  = pid_q;
  assign prio_o = prio_q;

endmodule

[rtl/core/spq_checker.sv]
// ---------------------------------------------------------------------------
// spq_checker: port-level checks for the stable priority queue
// Watches the result channel for consistent status, payload and occupancy.
// ---------------------------------------------------------------------------
module spq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_o,
  input logic       res_ready_i,
  input logic       out_valid_o,
  input logic [7:0] out_pid_o,
  input logic [7:0] out_priority_o,
  input logic [1:0] status_o,
  input logic [4:0] occupancy_out_o
);

  // a returned entry always reports ok status
  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> status_o == spq_pkg::ST_OK)
    else $error("returned entry with error status");

  // empty remove reports zero payload and an empty queue
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == spq_pkg::ST_EMPTY |->
      !out_valid_o && out_pid_o == 8'd0 && out_priority_o == 8'd0 &&
      occupancy_out_o == 5'd0)
    else $error("empty remove with bad payload");

  // dropped insert only when the queue is at capacity
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == spq_pkg::ST_FULL |->
      occupancy_out_o == 5'(QUEUE_DEPTH) && !out_valid_o)
    else $error("dropped insert while not full");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=>
      res_valid_o && $stable(out_pid_o) && $stable(status_o) &&
      $stable(occupancy_out_o))
    else $error("stalled result changed");

endmodule

bind stable_priority_queue spq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_checker (.*);

[verif/stable_priority_queue_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stable_priority_queue_test: self-checking bench for the sorted ready queue
// A short table of directed items (empty removes, extremes, ties, full queue)
// is followed by random fill and drain bursts. Each accepted item is run
// through a local queue model and every result is compared field by field.
// ---------------------------------------------------------------------------
module stable_priority_queue_test;

  localparam int  DEPTH            = 16;
  localparam int  RANDOM_ITEMS     = 1025;
  localparam int  MAX_GAP          = 18;
  localparam int  LONG_HOLD_AT     = 400;   // result count at which the sink stalls long
  localparam int  LONG_HOLD_CYCLES = 120;
  localparam int  IDLE_LIMIT       = 2000;  // cycles with no item moving on either side
  localparam int  TAIL_CYCLES      = 8;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // One result item
  typedef struct packed {
    logic       out_valid;
    logic [7:0] pid;
    logic [7:0] prio;
    logic [1:0] status;
    logic [4:0] occupancy;
  } queue_result_t;

  // One row of the directed table; pid counts up over repeats
  typedef struct packed {
    logic          mode;
    logic [7:0]    pid;
    logic [7:0]    prio;
    logic [4:0]    reps;
    logic          typed;   // row carries its own expected result
    queue_result_t want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 10;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // remove on an empty queue right after reset
    '{MODE_REMOVE, 8'h00, 8'h00, 5'd1,  1'b1,
      '{1'b0, 8'h00, 8'h00, spq_pkg::ST_EMPTY, 5'd0}},
    // extremes, and a tie at the top priority
    '{MODE_INSERT, 8'hFF, 8'hFF, 5'd1,  1'b1,
      '{1'b0, 8'h00, 8'h00, spq_pkg::ST_OK,    5'd1}},
    '{MODE_INSERT, 8'h00, 8'h00, 5'd1,  1'b1,
      '{1'b0, 8'h00, 8'h00, spq_pkg::ST_OK,    5'd2}},
    '{MODE_INSERT, 8'hAA, 8'hFF, 5'd1,  1'b1,
      '{1'b0, 8'h00, 8'h00, spq_pkg::ST_OK,    5'd3}},
    // removes ignore the payload; ties leave in arrival order
    '{MODE_REMOVE, 8'h5A, 8'hA5, 5'd1,  1'b1,
      '{1'b1, 8'hFF, 8'hFF, spq_pkg::ST_OK,    5'd2}},
    '{MODE_REMOVE, 8'hA5, 8'h5A, 5'd1,  1'b1,
      '{1'b1, 8'hAA, 8'hFF, spq_pkg::ST_OK,    5'd1}},
    '{MODE_REMOVE, 8'hFF, 8'hFF, 5'd1,  1'b1,
      '{1'b1, 8'h00, 8'h00, spq_pkg::ST_OK,    5'd0}},
    // fill to the brim with equal priorities
    '{MODE_INSERT, 8'h10, 8'h40, 5'd16, 1'b0, '0},
    // inserts into a full queue are dropped
    '{MODE_INSERT, 8'hFF, 8'hFF, 5'd1,  1'b1,
      '{1'b0, 8'h00, 8'h00, spq_pkg::ST_FULL,  5'd16}},
    '{MODE_INSERT, 8'h00, 8'h00, 5'd1,  1'b1,
      '{1'b0, 8'h00, 8'h00, spq_pkg::ST_FULL,  5'd16}}
  };

  logic       clk_i     = 1'b0;
  logic       rst_n     = 1'b0;
  logic       req_valid = 1'b0;
  logic       req_mode  = MODE_INSERT;
  logic [7:0] req_pid   = 8'h00;
  logic [7:0] req_prio  = 8'h00;
  logic       res_ready = 1'b0;

  logic       req_ready_o;
  logic       res_valid_o;
  logic       out_valid_o;
  logic [7:0] out_pid_o;
  logic [7:0] out_priority_o;
  logic [1:0] status_o;
  logic [4:0] occupancy_out_o;

  stable_priority_queue #(
    .QUEUE_DEPTH   (DEPTH),
    .PRIORITY_BITS (8)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .req_valid_i     (req_valid),
    .req_ready_o     (req_ready_o),
    .mode_i          (req_mode),
    .new_pid_i       (req_pid),
    .new_priority_i  (req_prio),
    .res_valid_o     (res_valid_o),
    .res_ready_i     (res_ready),
    .out_valid_o     (out_valid_o),
    .out_pid_o       (out_pid_o),
    .out_priority_o  (out_priority_o),
    .status_o        (status_o),
    .occupancy_out_o (occupancy_out_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model of the queue contents, head in slot 0
  logic [7:0]    ready_pid  [DEPTH];
  logic [7:0]    ready_prio [DEPTH];
  int            ready_count = 0;
  queue_result_t pending_results [$];
  int            mismatch_count = 0;

  // Apply one item to the model and return the result it yields
  function automatic queue_result_t apply_to_ready_queue(input logic mode,
                                                         input logic [7:0] pid,
                                                         input logic [7:0] prio);
    queue_result_t r;
    int            pos;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (mode == MODE_INSERT) begin
      if (ready_count >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // go behind every entry of equal or higher priority
        pos = 0;
        while (pos < ready_count && ready_prio[pos] >= prio) pos++;
        for (int i = ready_count; i > pos; i--) begin
          ready_pid[i]  = ready_pid[i-1];
          ready_prio[i] = ready_prio[i-1];
        end
        ready_pid[pos]  = pid;
        ready_prio[pos] = prio;
        ready_count++;
      end
    end else begin
      if (ready_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.out_valid = 1'b1;
        r.pid       = ready_pid[0];
        r.prio      = ready_prio[0];
        for (int i = 0; i + 1 < ready_count; i++) begin
          ready_pid[i]  = ready_pid[i+1];
          ready_prio[i] = ready_prio[i+1];
        end
        ready_count--;
      end
    end
    r.occupancy = ready_count[4:0];
    return r;
  endfunction

  // Offer one item after a gap, wait for it to be taken, record its result
  task automatic offer_item(input int gap, input logic mode, input logic [7:0] pid,
                            input logic [7:0] prio, input logic typed,
                            input queue_result_t want);
    queue_result_t predicted;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_mode  <= mode;
    req_pid   <= pid;
    req_prio  <= prio;
    do @(posedge clk_i); while (!req_ready_o);
    predicted = apply_to_ready_queue(mode, pid, prio);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Sender pause: hold back until every outstanding result is out
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Result sink with random stalls and one long hold-off
  initial begin : result_sink
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    while (!rst_n) @(posedge clk_i);
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
      else if (calm) stall = 0;
      else stall = $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ready <= 1'b1;
      do @(posedge clk_i); while (!res_valid_o);
      taken++;
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    queue_result_t want;
    if (rst_n && res_valid_o && res_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no item outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_valid_o !== want.out_valid) begin
          $error("out_valid: expected %0d, actual %0d", want.out_valid, out_valid_o);
          mismatch_count++;
        end
        if (out_pid_o !== want.pid) begin
          $error("out_pid: expected %0d, actual %0d", want.pid, out_pid_o);
          mismatch_count++;
        end
        if (out_priority_o !== want.prio) begin
          $error("out_priority: expected %0d, actual %0d", want.prio, out_priority_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatch_count++;
        end
        if (occupancy_out_o !== want.occupancy) begin
          $error("occupancy_out: expected %0d, actual %0d", want.occupancy,
                 occupancy_out_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long with no item moving on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_valid && req_ready_o) || (res_valid_o && res_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("stable_priority_queue_test NOT OK");
    $finish;
  end

  // Stimulus: directed table, then random bursts
  initial begin : stimulus
    int         sent;
    int         burst_kind;
    int         burst_len;
    int         prio_style;
    bit         no_gaps;
    logic       mode;
    logic [7:0] prio;
    int         gap;

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        offer_item($urandom_range(0, MAX_GAP), directed_rows[r].mode,
                   directed_rows[r].pid + 8'(k), directed_rows[r].prio,
                   directed_rows[r].typed, directed_rows[r].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // fill bursts, drain bursts and mixed noise
      burst_kind = $urandom_range(0, 3);
      burst_len  = $urandom_range(1, 20);
      prio_style = $urandom_range(0, 2);
      no_gaps    = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
        case (burst_kind)
          0: begin
            mode = ($urandom_range(0, 7) == 0) ? MODE_REMOVE : MODE_INSERT;
          end
          1: begin
            mode = ($urandom_range(0, 7) == 0) ? MODE_INSERT : MODE_REMOVE;
          end
          default: begin
            mode = $urandom_range(0, 1) ? MODE_REMOVE : MODE_INSERT;
          end
        endcase
        case (prio_style)
          0: prio = 8'($urandom_range(0, 255));
          1: prio = 8'($urandom_range(0, 3));        // many ties
          default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        offer_item(gap, mode, 8'($urandom_range(0, 255)), prio, 1'b0, '0);
        sent++;
        if (sent == RANDOM_ITEMS / 2) wait_for_drain();
      end
    end
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("stable_priority_queue_test OK");
    end else begin
      $display("stable_priority_queue_test NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue.sv
rtl/core/spq_checker.sv
verif/stable_priority_queue_test.sv
